[rtl/lsf_pkg.sv]
// Package: sizes and helpers shared by the learning forwarder files.
`timescale 1ns / 1ps
`default_nettype none
package lsf_pkg;

  localparam int PORT_COUNT    = 8;
  localparam int TABLE_ENTRIES = 16;

  localparam int PORT_W    = 3;
  localparam int STATION_W = 16;
  localparam int MASK_W    = 8;
  localparam int FILL_W    = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [MASK_W-1:0] PORT_BITS = MASK_W'((1 << PORT_COUNT) - 1);

  typedef logic [PORT_W-1:0]    port_t;
  typedef logic [STATION_W-1:0] station_t;
  typedef logic [MASK_W-1:0]    mask_t;
  typedef logic [FILL_W-1:0]    fill_t;

  // One-hot bit for a port, zero for ports beyond the fitted count
  function automatic mask_t port_bit(input port_t p);
    mask_t b;
    b = '0;
    if (32'(p) < PORT_COUNT) begin
      b = mask_t'(1) << p;
    end
    return b & PORT_BITS;
  endfunction

endpackage
`default_nettype wire

[rtl/lsf_if.sv]
// Interfaces: frame header channel and forwarding result channel.
`timescale 1ns / 1ps
`default_nettype none
interface lsf_in_if
  import lsf_pkg::*;
();
  logic     valid;
  logic     ready;
  port_t    arrival_port;
  station_t source_id;
  station_t dest_id;

  modport source (output valid, output arrival_port, output source_id, output dest_id,
                  input ready);
  modport sink   (input valid, input arrival_port, input source_id, input dest_id,
                  output ready);
endinterface

interface lsf_out_if
  import lsf_pkg::*;
();
  logic  valid;
  logic  ready;
  mask_t forward_mask;
  logic  flooded;
  logic  source_learned;
  logic  learn_dropped;

  modport source (output valid, output forward_mask, output flooded,
                  output source_learned, output learn_dropped, input ready);
  modport sink   (input valid, input forward_mask, input flooded,
                  input source_learned, input learn_dropped, output ready);
endinterface
`default_nettype wire

[rtl/learning_switch_forwarder_unit.sv]
// Top level: learning layer-2 forwarder with a fully associative address table.
`timescale 1ns / 1ps
`default_nettype none
// Takes one frame header beat per cycle unless out_res back-pressure stalls it,
// and returns one result beat per header, passed through the header register and
// then the result register. The address table is a row of TABLE_ENTRIES
// flip-flop entries compared in parallel against source and destination;
// entries fill in order, are never aged or moved, and a fill count stands in
// for per-entry valid bits. A new source is learned as its header passes to
// the result register, so the next header already sees it. cfg_wdata sets
// the active port mask; write it only while no beat is in flight.
module learning_switch_forwarder_unit
  import lsf_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  lsf_in_if.sink       in_hdr,
  lsf_out_if.source    out_res,
  input  wire          cfg_we,
  input  wire [MASK_W-1:0] cfg_wdata
);

  mask_t    active_r;

  logic     s1_vld_r;
  port_t    s1_arrival_r;
  station_t s1_source_r;
  station_t s1_dest_r;

  logic     out_vld_r;
  mask_t    out_mask_r;
  logic     out_flood_r;
  logic     out_learn_r;
  logic     out_drop_r;

  station_t entry_station_r [TABLE_ENTRIES];
  port_t    entry_port_r    [TABLE_ENTRIES];
  fill_t    fill_count_r;

  logic     s1_go;
  logic     src_known;
  logic     dst_known;
  port_t    dst_port;
  logic     full;
  logic     learn;
  logic     drop;
  logic     self_hit;
  logic     dst_hit;
  mask_t    active;
  mask_t    fwd_nxt;

  assign s1_go        = !out_vld_r || out_res.ready;
  assign in_hdr.ready = !s1_vld_r || s1_go;
  assign active       = active_r & PORT_BITS;
  assign full         = (fill_count_r == FILL_W'(TABLE_ENTRIES));

  // Parallel compare over the used part of the table
  always_comb begin
    src_known = 1'b0;
    dst_known = 1'b0;
    dst_port  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (FILL_W'(i) < fill_count_r) begin
        if (entry_station_r[i] == s1_source_r) begin
          src_known = 1'b1;
        end
        if (entry_station_r[i] == s1_dest_r) begin
          dst_known = 1'b1;
          dst_port  = dst_port | entry_port_r[i];
        end
      end
    end
  end

  assign learn    = !src_known && !full;
  assign drop     = !src_known && full;
  // Destination is looked up after learning: a frame to its own sender hits
  assign self_hit = learn && (s1_dest_r == s1_source_r);
  assign dst_hit  = dst_known || self_hit;

  always_comb begin
    if (dst_hit) begin
      fwd_nxt = port_bit(self_hit ? s1_arrival_r : dst_port) & active;
    end else begin
      fwd_nxt = active & ~port_bit(s1_arrival_r) & PORT_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= '0;
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      fill_count_r <= '0;
    end else begin
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
      if (in_hdr.ready) begin
        s1_vld_r <= in_hdr.valid;
      end
      if (s1_go) begin
        out_vld_r <= s1_vld_r;
      end
      if (s1_go && s1_vld_r && learn) begin
        fill_count_r <= fill_count_r + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_hdr.ready && in_hdr.valid) begin
      s1_arrival_r <= in_hdr.arrival_port;
      s1_source_r  <= in_hdr.source_id;
      s1_dest_r    <= in_hdr.dest_id;
    end
    if (s1_go && s1_vld_r) begin
      out_mask_r  <= fwd_nxt;
      out_flood_r <= !dst_hit;
      out_learn_r <= learn;
      out_drop_r  <= drop;
      if (learn) begin
        entry_station_r[fill_count_r[IDX_W-1:0]] <= s1_source_r;
        entry_port_r[fill_count_r[IDX_W-1:0]]    <= s1_arrival_r;
      end
    end
  end

  assign out_res.valid          = out_vld_r;
  assign out_res.forward_mask   = out_mask_r;
  assign out_res.flooded        = out_flood_r;
  assign out_res.source_learned = out_learn_r;
  assign out_res.learn_dropped  = out_drop_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= FILL_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_learn_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_vld_r && learn) |=> fill_count_r == $past(fill_count_r) + FILL_W'(1))
    else $error("learned entry did not advance fill count");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_learn_r && out_drop_r))
    else $error("learned and dropped together");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_drop_r) |-> full)
    else $error("learn dropped while table not full");

endmodule
`default_nettype wire
